// ===== design/lru_pkg.sv =====
`default_nettype none

package lru_pkg;

    // Storage geometry.
    localparam int FRAMES    = 8;
    localparam int PAGE_BITS = 16;

    localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(FRAMES + 1);

    // Fixed field widths of the stream payloads.
    localparam int PAGE_FIELD_W  = 16;
    localparam int SLOT_FIELD_W  = 3;
    localparam int TOTAL_FIELD_W = 16;
    localparam int CFG_W         = 4;

    localparam logic [TOTAL_FIELD_W-1:0] FAULT_MAX = '1;

    // Configuration register map.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_FRAMES_IN_USE = '0;
    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = CFG_W'(8);

    typedef logic [PAGE_BITS-1:0] page_t;
    typedef logic [RANK_W-1:0]    rank_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_COMMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;    // capture the incoming page
        logic lookup;  // register hit search and victim choice
        logic commit;  // update frames and load the result register
    } cmd_t;

    function automatic page_t page_from_field(input logic [PAGE_FIELD_W-1:0] f);
        logic [PAGE_FIELD_W+PAGE_BITS-1:0] t;
        t = {{PAGE_BITS{1'b0}}, f};
        return t[PAGE_BITS-1:0];
    endfunction

    function automatic logic [PAGE_FIELD_W-1:0] field_from_page(input page_t p);
        logic [PAGE_FIELD_W+PAGE_BITS-1:0] t;
        t = {{PAGE_FIELD_W{1'b0}}, p};
        return t[PAGE_FIELD_W-1:0];
    endfunction

    function automatic logic [SLOT_FIELD_W-1:0] slot_from_idx(input idx_t k);
        logic [SLOT_FIELD_W+IDX_W-1:0] t;
        t = {{SLOT_FIELD_W{1'b0}}, k};
        return t[SLOT_FIELD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/lru_ctrl.sv =====
`default_nettype none

module lru_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output lru_pkg::cmd_t      cmd
);
    import lru_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.take   = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                cmd.lookup = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                // The result register must be free or draining this cycle.
                if (!out_valid_reg || out_ready) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== design/lru_datapath.sv =====
`default_nettype none

module lru_datapath (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire lru_pkg::cmd_t                        cmd,
    input  wire logic [lru_pkg::PAGE_FIELD_W-1:0]     in_page,
    input  wire logic [lru_pkg::CFG_W-1:0]            frames_in_use,
    output logic                                      res_hit,
    output logic [lru_pkg::SLOT_FIELD_W-1:0]          res_slot,
    output logic                                      res_evicted_valid,
    output logic [lru_pkg::PAGE_FIELD_W-1:0]          res_evicted_page,
    output logic [lru_pkg::TOTAL_FIELD_W-1:0]         res_fault_total
);
    import lru_pkg::*;

    // Frame store.
    page_t page_reg [FRAMES];
    page_t page_next [FRAMES];
    rank_t rank_reg [FRAMES];
    rank_t rank_next [FRAMES];
    cnt_t  filled_reg, filled_next;
    logic [TOTAL_FIELD_W-1:0] fault_reg, fault_next;

    // Item in flight.
    page_t pin_reg;
    logic  hit_reg;
    logic  full_reg;
    idx_t  k_reg;

    // Result register.
    logic                      res_hit_reg;
    logic [SLOT_FIELD_W-1:0]   res_slot_reg;
    logic                      res_ev_valid_reg;
    logic [PAGE_FIELD_W-1:0]   res_ev_page_reg;
    logic [TOTAL_FIELD_W-1:0]  res_fault_reg;

    // Lookup signals.
    cnt_t  act_frames;
    cnt_t  limit;
    logic  found;
    idx_t  hit_idx;
    idx_t  victim;
    rank_t best_rank;
    logic  full;
    rank_t rank_k;

    // Out-of-range settings collapse to one frame or to all frames.
    always_comb begin
        if (frames_in_use == '0) begin
            act_frames = CNT_W'(1);
        end else if (int'(frames_in_use) > FRAMES) begin
            act_frames = CNT_W'(FRAMES);
        end else begin
            act_frames = CNT_W'(frames_in_use);
        end
    end

    // Parallel compare over the active filled frames; the highest match wins.
    // The victim is the first active frame holding the largest rank.
    always_comb begin
        limit     = (filled_reg < act_frames) ? filled_reg : act_frames;
        full      = (filled_reg >= act_frames);
        found     = 1'b0;
        hit_idx   = '0;
        victim    = '0;
        best_rank = rank_reg[0];
        for (int i = 0; i < FRAMES; i++) begin
            if (CNT_W'(i) < limit && page_reg[i] == pin_reg) begin
                found   = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
        for (int i = 1; i < FRAMES; i++) begin
            if (CNT_W'(i) < act_frames && rank_reg[i] > best_rank) begin
                best_rank = rank_reg[i];
                victim    = IDX_W'(i);
            end
        end
    end

    // Commit: age the frames and place the page.
    always_comb begin
        page_next   = page_reg;
        rank_next   = rank_reg;
        filled_next = filled_reg;
        fault_next  = fault_reg;
        rank_k      = rank_reg[k_reg];
        if (cmd.commit) begin
            if (!hit_reg && fault_reg != FAULT_MAX) begin
                fault_next = fault_reg + TOTAL_FIELD_W'(1);
            end
            if (hit_reg || full_reg) begin
                // Frames newer than the touched one grow one step older.
                for (int i = 0; i < FRAMES; i++) begin
                    if (CNT_W'(i) < filled_reg && rank_reg[i] < rank_k) begin
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                    end
                end
            end else begin
                // Filling a free frame ages every filled frame.
                for (int i = 0; i < FRAMES; i++) begin
                    if (CNT_W'(i) < filled_reg) begin
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                    end
                end
                filled_next = filled_reg + CNT_W'(1);
            end
            rank_next[k_reg] = '0;
            if (!hit_reg) begin
                page_next[k_reg] = pin_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filled_reg <= '0;
            fault_reg  <= '0;
        end else begin
            filled_reg <= filled_next;
            fault_reg  <= fault_next;
        end
    end

    always_ff @(posedge aclk) begin
        page_reg <= page_next;
        rank_reg <= rank_next;
        if (cmd.take) begin
            pin_reg <= page_from_field(in_page);
        end
        if (cmd.lookup) begin
            hit_reg  <= found;
            full_reg <= full;
            if (found) begin
                k_reg <= hit_idx;
            end else if (full) begin
                k_reg <= victim;
            end else begin
                k_reg <= filled_reg[IDX_W-1:0];
            end
        end
        if (cmd.commit) begin
            res_hit_reg      <= hit_reg;
            res_slot_reg     <= slot_from_idx(k_reg);
            res_ev_valid_reg <= !hit_reg && full_reg;
            res_ev_page_reg  <= (!hit_reg && full_reg) ? field_from_page(page_reg[k_reg])
                                                       : '0;
            res_fault_reg    <= fault_next;
        end
    end

    assign res_hit           = res_hit_reg;
    assign res_slot          = res_slot_reg;
    assign res_evicted_valid = res_ev_valid_reg;
    assign res_evicted_page  = res_ev_page_reg;
    assign res_fault_total   = res_fault_reg;

endmodule

`default_nettype wire

// ===== design/lru_page_replacement_unit.sv =====
// Channel  | Direction | Fields
// ---------+-----------+------------------------------------------------------------
// s_*      | in        | tdata[15:0] page
// m_*      | out       | tuser[0] hit; tdata[2:0] slot, [3] evicted_valid,
//          |           | [19:4] evicted_page, [35:20] fault_total, [39:36] zero
// APB      | in/out    | 0x0 frames_in_use[3:0], reset value 8
//
// Each reference passes through three steps: accepting the page, the
// parallel tag compare and victim search over the frames, and updating the
// frames and loading the result register. No new page is taken before commit.
// The commit step waits only while the result register is full and m_tready is
// low; an accepted result frees the register in the same cycle.
// Reset is synchronous and active low; it empties all frames and clears the
// fault total. Frame contents are not cleared, as only filled frames are read.
`default_nettype none

module lru_page_replacement_unit (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // Input stream.
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [15:0]                          s_tdata,   // [15:0] page
    // Result stream.
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [39:0]                               m_tdata,   // slot, evicted_valid,
                                                                 // evicted_page, fault_total
    output logic                                      m_tuser,   // hit
    // Configuration port.
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [lru_pkg::APB_ADDR_W-1:0]       paddr,
    input  wire logic [lru_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [lru_pkg::APB_DATA_W-1:0]            prdata,
    output logic                                      pready
);
    import lru_pkg::*;

    cmd_t cmd;
    logic [CFG_W-1:0] frames_in_use_reg;

    logic                      res_hit;
    logic [SLOT_FIELD_W-1:0]   res_slot;
    logic                      res_evicted_valid;
    logic [PAGE_FIELD_W-1:0]   res_evicted_page;
    logic [TOTAL_FIELD_W-1:0]  res_fault_total;

    // The register is written in the access phase of an APB write transaction.
    // Writes to addresses beyond the register map are dropped.
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_in_use_reg <= FRAMES_IN_USE_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[APB_ADDR_W-1:2] == REG_FRAMES_IN_USE) begin
            frames_in_use_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1:2] == REG_FRAMES_IN_USE) begin
            prdata = {{(APB_DATA_W-CFG_W){1'b0}}, frames_in_use_reg};
        end
    end

    // The controller sequences each transaction; the datapath holds the frames.
    lru_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    lru_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .in_page           (s_tdata),
        .frames_in_use     (frames_in_use_reg),
        .res_hit           (res_hit),
        .res_slot          (res_slot),
        .res_evicted_valid (res_evicted_valid),
        .res_evicted_page  (res_evicted_page),
        .res_fault_total   (res_fault_total)
    );

    assign m_tuser = res_hit;
    assign m_tdata = {4'b0000, res_fault_total, res_evicted_page,
                      res_evicted_valid, res_slot};

`ifndef ASSERT_OFF
    // Only one reference is in flight, so an accepted transaction closes the
    // input until it has been committed.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a reference was in flight");

    // A hit never evicts a page.
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser && m_tdata[3]))
        else $error("hit reported together with an eviction");

    // Without an eviction the evicted page reads as zero.
    a_evict_page_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[3] |-> m_tdata[19:4] == 16'h0000)
        else $error("evicted page nonzero without an eviction");

    // A result that waits for the receiver stays valid and unchanged.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while waiting for the receiver");
`endif

endmodule

`default_nettype wire
